@@ src/growing_slot_pool_allocator_defines.svh @@
// Assertion macros shared by the slot pool allocator modules.
`ifndef GROWING_SLOT_POOL_ALLOCATOR_DEFINES_SVH
`define GROWING_SLOT_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSPA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gspa: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSPA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gspa: next-cycle check failed");

`endif

@@ src/gspa_pkg.sv @@
// Types, codes and constants shared by the slot pool allocator modules.
package gspa_pkg;

    // Default number of hardware slots.
    localparam int SLOT_COUNT_DEF = 1024;
    // Growth size at start-up and when the grow step register reads zero.
    localparam int DEFAULT_STEP = 32;

    // Fixed field widths.
    localparam int HANDLE_W  = 10;
    localparam int CNT_W     = 11;
    localparam int SEQ_W     = 64;
    localparam int GUARD_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Request codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_EXHAUSTED   = 2'd1,
        STAT_BAD_HANDLE  = 2'd2,
        STAT_DOUBLE_FREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_GROW,
        ST_RD,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic                req_type;
        logic [HANDLE_W-1:0] slot_handle;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] granted_slot;
        logic [SEQ_W-1:0]    grant_sequence;
        logic [CNT_W-1:0]    in_use_count;
        logic [CNT_W-1:0]    free_count;
        logic [CNT_W-1:0]    created_count;
        logic [GUARD_W-1:0]  guard_failures;
    } rsp_t;

    typedef struct packed {
        logic [CNT_W-1:0] grow_step;
        logic [CNT_W-1:0] capacity_limit;
    } cfg_t;

endpackage

@@ src/gspa_ram.sv @@
// Simple dual-port synchronous RAM with one write port and a registered read port.
module gspa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/gspa_ctrl.sv @@
// Sequencer and counters of the slot pool allocator: growth, pop, push and result register.
`include "growing_slot_pool_allocator_defines.svh"

module gspa_ctrl #(
    parameter int SLOT_COUNT = gspa_pkg::SLOT_COUNT_DEF,
    localparam int IW = $clog2(SLOT_COUNT)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  gspa_pkg::cfg_t  cfg,
    input  logic            s_valid,
    output logic            s_ready,
    input  gspa_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output gspa_pkg::rsp_t  m_data,
    // Free stack memory port.
    output logic            stk_we,
    output logic [IW-1:0]   stk_waddr,
    output logic [IW-1:0]   stk_wdata,
    output logic            stk_re,
    output logic [IW-1:0]   stk_raddr,
    input  logic [IW-1:0]   stk_rdata,
    // Active mark memory port.
    output logic            act_we,
    output logic [IW-1:0]   act_waddr,
    output logic            act_wdata,
    output logic            act_re,
    output logic [IW-1:0]   act_raddr,
    input  logic            act_rdata
);

    import gspa_pkg::*;

    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int KW = (CW > CNT_W) ? CW : CNT_W;
    localparam int START_N = (DEFAULT_STEP < SLOT_COUNT) ? DEFAULT_STEP : SLOT_COUNT;

    state_t               state_reg, state_next;
    logic [CW-1:0]        depth_reg, depth_next;
    logic [CW-1:0]        created_reg, created_next;
    logic [CW-1:0]        inuse_reg, inuse_next;
    logic [CW-1:0]        grow_left_reg, grow_left_next;
    logic [SEQ_W-1:0]     seq_reg, seq_next;
    logic [GUARD_W-1:0]   guard_reg, guard_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_data_reg, out_data_next;
    req_t                 req_reg, req_next;

    logic [KW-1:0]        slot_max;
    logic [KW-1:0]        step_eff;
    logic [KW-1:0]        lim_eff;
    logic [KW-1:0]        created_k;
    logic [KW-1:0]        room;
    logic [KW-1:0]        grow_n;
    logic [KW-1:0]        handle_k;
    logic                 can_grow;
    logic                 grow_act;
    logic                 exec_fire;
    logic                 accept;
    logic                 need_grow;
    logic                 alloc_ok;
    logic                 free_bad;
    logic                 free_ok;
    logic                 is_alloc;

    // Effective growth size and capacity limit.
    always_comb begin
        slot_max = KW'(SLOT_COUNT);
        step_eff = KW'(cfg.grow_step);
        if (cfg.grow_step == '0) begin
            step_eff = KW'(DEFAULT_STEP);
        end
        if (step_eff > slot_max) begin
            step_eff = slot_max;
        end
        lim_eff = KW'(cfg.capacity_limit);
        if (cfg.capacity_limit == '0 || lim_eff > slot_max) begin
            lim_eff = slot_max;
        end
        created_k = KW'(created_reg);
        can_grow  = created_k < lim_eff;
        room      = lim_eff - created_k;
        grow_n    = (step_eff < room) ? step_eff : room;
    end

    // Request classification.
    always_comb begin
        accept    = (state_reg == ST_IDLE) && s_valid;
        need_grow = (s_data.req_type == REQ_ALLOC) && (depth_reg == '0) && can_grow;
        exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || m_ready);
        grow_act  = (state_reg == ST_INIT) || (state_reg == ST_GROW);
        is_alloc  = req_reg.req_type == REQ_ALLOC;
        handle_k  = KW'(req_reg.slot_handle);
        alloc_ok  = is_alloc && (depth_reg != '0);
        free_bad  = !is_alloc && ((handle_k >= created_k) || (handle_k >= slot_max));
        free_ok   = !is_alloc && !free_bad && act_rdata;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (grow_left_reg == CW'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = need_grow ? ST_GROW : ST_EXEC;
                end
            end
            ST_GROW: begin
                if (grow_left_reg == CW'(1)) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory port outputs.
    always_comb begin
        s_ready   = state_reg == ST_IDLE;
        m_valid   = out_valid_reg;
        m_data    = out_data_reg;

        // Top of stack is read on acceptance and again after a growth.
        stk_re    = accept || (state_reg == ST_RD);
        stk_raddr = IW'(depth_reg - CW'(1));
        act_re    = accept;
        act_raddr = IW'(s_data.slot_handle);

        stk_we    = grow_act || (exec_fire && free_ok && (KW'(depth_reg) < slot_max));
        stk_waddr = IW'(depth_reg);
        stk_wdata = grow_act ? IW'(created_reg) : IW'(req_reg.slot_handle);

        act_we    = grow_act || (exec_fire && (alloc_ok || free_ok));
        act_waddr = IW'(req_reg.slot_handle);
        act_wdata = 1'b0;
        if (grow_act) begin
            act_waddr = IW'(created_reg);
        end else if (is_alloc) begin
            act_waddr = stk_rdata;
            act_wdata = 1'b1;
        end
    end

    // Counter updates and result assembly.
    always_comb begin
        depth_next     = depth_reg;
        created_next   = created_reg;
        inuse_next     = inuse_reg;
        grow_left_next = grow_left_reg;
        seq_next       = seq_reg;
        guard_next     = guard_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;

        // Each growth cycle creates one slot and pushes it.
        if (grow_act) begin
            depth_next     = depth_reg + CW'(1);
            created_next   = created_reg + CW'(1);
            grow_left_next = grow_left_reg - CW'(1);
        end

        if (accept) begin
            req_next = s_data;
            if (need_grow) begin
                grow_left_next = CW'(grow_n);
            end
        end

        if (exec_fire) begin
            out_valid_next               = 1'b1;
            out_data_next.status         = STAT_OK;
            out_data_next.granted_slot   = '0;
            out_data_next.grant_sequence = '0;
            if (is_alloc) begin
                if (alloc_ok) begin
                    depth_next                   = depth_reg - CW'(1);
                    inuse_next                   = inuse_reg + CW'(1);
                    seq_next                     = seq_reg + SEQ_W'(1);
                    out_data_next.granted_slot   = HANDLE_W'(stk_rdata);
                    out_data_next.grant_sequence = seq_reg + SEQ_W'(1);
                end else begin
                    out_data_next.status = STAT_EXHAUSTED;
                end
            end else if (free_bad) begin
                out_data_next.status = STAT_BAD_HANDLE;
                if (guard_reg != '1) begin
                    guard_next = guard_reg + GUARD_W'(1);
                end
            end else if (!free_ok) begin
                out_data_next.status = STAT_DOUBLE_FREE;
            end else begin
                if (KW'(depth_reg) < slot_max) begin
                    depth_next = depth_reg + CW'(1);
                end
                if (inuse_reg != '0) begin
                    inuse_next = inuse_reg - CW'(1);
                end
            end
            out_data_next.in_use_count   = CNT_W'(inuse_next);
            out_data_next.free_count     = CNT_W'(depth_next);
            out_data_next.created_count  = CNT_W'(created_next);
            out_data_next.guard_failures = guard_next;
        end
    end

    // Control registers; reset starts the initial growth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            depth_reg     <= '0;
            created_reg   <= '0;
            inuse_reg     <= '0;
            grow_left_reg <= CW'(START_N);
            seq_reg       <= '0;
            guard_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            created_reg   <= created_next;
            inuse_reg     <= inuse_next;
            grow_left_reg <= grow_left_next;
            seq_reg       <= seq_next;
            guard_reg     <= guard_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        req_reg      <= req_next;
    end

    // Every created slot is either on the free stack or in use.
    `GSPA_ASSERT_IMP(a_slot_balance, aclk, aresetn, 1'b1, ((CW+1)'(depth_reg) + (CW+1)'(inuse_reg)) == (CW+1)'(created_reg))
    // The pool never grows past the hardware slot count.
    `GSPA_ASSERT_IMP(a_created_max, aclk, aresetn, 1'b1, created_reg <= CW'(SLOT_COUNT))
    // An accepted request goes straight to growth or execution.
    `GSPA_ASSERT_NEXT(a_accept_flow, aclk, aresetn, accept, (state_reg == ST_GROW) || (state_reg == ST_EXEC))
    // Only a successful grant carries a slot and a sequence stamp.
    `GSPA_ASSERT_IMP(a_grant_zero, aclk, aresetn, m_valid && (m_data.status != STAT_OK), (m_data.grant_sequence == '0) && (m_data.granted_slot == '0))

endmodule

@@ src/growing_slot_pool_allocator.sv @@
// Top level of the slot pool allocator: configuration registers, sequencer and two memories.
//
//  Channel  | Ports                             | Moves per transfer
//  ---------+-----------------------------------+------------------------------------
//  request  | s_valid, s_ready, s_data          | req_type, slot_handle
//  result   | m_valid, m_ready, m_data          | status, slot, sequence, four counts
//  config   | cfg_valid, cfg_ready, cfg_index,  | grow_step (index 0),
//           | cfg_data                          | capacity_limit (index 1)
//
// An allocate or free does one free stack / active mark read, then the write-back.
// An allocate that finds the stack empty below the capacity limit first grows the pool
// at one slot per cycle, then re-reads the stack top.
// After reset the start-up growth pushes min(32, SLOT_COUNT) slots, one per cycle,
// with s_ready low; the config port is always ready.
// A result waits in the output register while the next request is accepted; that
// request's write-back holds until the output register is taken.
module growing_slot_pool_allocator #(
    parameter int SLOT_COUNT = gspa_pkg::SLOT_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  gspa_pkg::req_t                      s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output gspa_pkg::rsp_t                      m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gspa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gspa_pkg::CNT_W-1:0]          cfg_data
);

    import gspa_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);

    logic [CNT_W-1:0] grow_step_reg;
    logic [CNT_W-1:0] cap_limit_reg;
    cfg_t             cfg;

    logic          stk_we, stk_re;
    logic [IW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
    logic          act_we, act_re, act_wdata, act_rdata;
    logic [IW-1:0] act_waddr, act_raddr;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grow_step_reg <= CNT_W'(DEFAULT_STEP);
            cap_limit_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_GROW_STEP) begin
                grow_step_reg <= cfg_data;
            end else if (cfg_index == CFG_CAP_LIMIT) begin
                cap_limit_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready          = 1'b1;
    assign cfg.grow_step      = grow_step_reg;
    assign cfg.capacity_limit = cap_limit_reg;

    // Sequencer and counters.
    gspa_ctrl #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .stk_we    (stk_we),
        .stk_waddr (stk_waddr),
        .stk_wdata (stk_wdata),
        .stk_re    (stk_re),
        .stk_raddr (stk_raddr),
        .stk_rdata (stk_rdata),
        .act_we    (act_we),
        .act_waddr (act_waddr),
        .act_wdata (act_wdata),
        .act_re    (act_re),
        .act_raddr (act_raddr),
        .act_rdata (act_rdata)
    );

    // Free stack of slot indexes.
    gspa_ram #(
        .DEPTH(SLOT_COUNT),
        .WIDTH(IW)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Active marks; each slot's mark is cleared as the slot is created.
    gspa_ram #(
        .DEPTH(SLOT_COUNT),
        .WIDTH(1)
    ) u_active_ram (
        .aclk  (aclk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .re    (act_re),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

endmodule

@@ test/tb_growing_slot_pool_allocator.sv @@
// Self-checking testbench for the slot pool allocator: directed and random requests checked against a tracked pool.
module tb_growing_slot_pool_allocator;
    import gspa_pkg::*;

    localparam int SLOTS          = SLOT_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;

    // Register indexes with no register behind them; writes there are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Tracks the pool as the block should see it and holds the results still to come.
    class slot_pool_tracker;
        logic [HANDLE_W-1:0] free_stack [SLOTS];
        bit                  active [SLOTS];
        logic [CNT_W-1:0]    depth;
        logic [CNT_W-1:0]    created;
        logic [CNT_W-1:0]    in_use;
        logic [SEQ_W-1:0]    seq_ctr;
        logic [GUARD_W-1:0]  guard;
        logic [CNT_W-1:0]    grow_reg;
        logic [CNT_W-1:0]    limit_reg;
        rsp_t                awaited_results [$];
        int                  errors;

        function new();
            foreach (active[i]) active[i] = 1'b0;
            depth     = '0;
            created   = '0;
            in_use    = '0;
            seq_ctr   = '0;
            guard     = '0;
            grow_reg  = CNT_W'(DEFAULT_STEP);
            limit_reg = '0;
            errors    = 0;
            // Reset runs one start-up growth with the reset register values.
            grow();
        endfunction

        function int unsigned eff_step();
            int unsigned s;
            s = grow_reg;
            if (s == 0) s = DEFAULT_STEP;
            if (s > SLOTS) s = SLOTS;
            return s;
        endfunction

        function int unsigned eff_limit();
            int unsigned l;
            l = limit_reg;
            if (l == 0 || l > SLOTS) l = SLOTS;
            return l;
        endfunction

        // Creates the next slot indexes and pushes them in ascending order.
        function void grow();
            int unsigned lim;
            int unsigned n;
            lim = eff_limit();
            if (created >= lim) return;
            n = eff_step();
            if (n > lim - created) n = lim - created;
            repeat (n) begin
                if (depth < SLOTS) begin
                    free_stack[depth] = created[HANDLE_W-1:0];
                    depth++;
                end
                created++;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
            if (idx == CFG_GROW_STEP) grow_reg = value;
            else if (idx == CFG_CAP_LIMIT) limit_reg = value;
        endfunction

        // Applies one accepted request and queues the result it should produce.
        function void note_request(req_t r);
            rsp_t                e;
            logic [HANDLE_W-1:0] h;
            e = '0;
            e.status = STAT_OK;
            h = r.slot_handle;
            if (r.req_type == REQ_ALLOC) begin
                if (depth == 0) grow();
                if (depth == 0) begin
                    e.status = STAT_EXHAUSTED;
                end else begin
                    depth--;
                    e.granted_slot = free_stack[depth];
                    active[free_stack[depth]] = 1'b1;
                    in_use++;
                    seq_ctr++;
                    e.grant_sequence = seq_ctr;
                end
            end else if (h >= created || h >= SLOTS) begin
                e.status = STAT_BAD_HANDLE;
                if (guard != '1) guard++;
            end else if (!active[h]) begin
                e.status = STAT_DOUBLE_FREE;
            end else begin
                active[h] = 1'b0;
                if (depth < SLOTS) begin
                    free_stack[depth] = h;
                    depth++;
                end
                if (in_use > 0) in_use--;
            end
            e.in_use_count   = in_use;
            e.free_count     = depth;
            e.created_count  = created;
            e.guard_failures = guard;
            awaited_results.push_back(e);
        endfunction

        function void report(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("mismatch: %s", what);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
                report($sformatf("%s expected %0h, actual %0h", field, want, got));
        endfunction

        // Checks one accepted result against the oldest expectation.
        function void check_result(rsp_t got);
            rsp_t want;
            if (awaited_results.size() == 0) begin
                report("result transfer with no request outstanding");
                return;
            end
            want = awaited_results.pop_front();
            compare("status", want.status, got.status);
            compare("granted_slot", want.granted_slot, got.granted_slot);
            compare("grant_sequence", want.grant_sequence, got.grant_sequence);
            compare("in_use_count", want.in_use_count, got.in_use_count);
            compare("free_count", want.free_count, got.free_count);
            compare("created_count", want.created_count, got.created_count);
            compare("guard_failures", want.guard_failures, got.guard_failures);
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Returns some active slot, or -1 when none is allocated.
        function int pick_active();
            int unsigned start;
            int unsigned idx;
            int          k;
            if (in_use == 0) return -1;
            start = $urandom_range(created - 1);
            for (k = 0; k < created; k++) begin
                idx = (start + k) % created;
                if (active[idx]) return idx;
            end
            return -1;
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    req_t                 s_data;
    logic                 m_valid;
    logic                 m_ready;
    rsp_t                 m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    slot_pool_tracker pool = new();

    growing_slot_pool_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic req_t request_of(logic kind, int handle);
        req_t r;
        r.req_type    = kind;
        r.slot_handle = HANDLE_W'(handle);
        return r;
    endfunction

    // Mostly well-formed traffic: allocations and frees of live slots, plus some noise.
    function automatic req_t make_request(int alloc_pct);
        req_t r;
        int   live;
        r.req_type    = REQ_ALLOC;
        r.slot_handle = HANDLE_W'($urandom_range(SLOTS - 1));
        if ($urandom_range(99) >= alloc_pct) begin
            r.req_type = REQ_FREE;
            live = pool.pick_active();
            if (live >= 0 && $urandom_range(3) != 0)
                r.slot_handle = HANDLE_W'(live);
            else if ($urandom_range(1) == 0)
                r.slot_handle = HANDLE_W'($urandom_range(pool.created - 1));
        end
        return r;
    endfunction

    // Holds one request on the input channel until its transfer.
    task automatic send(input req_t r);
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        pool.note_request(r);
    endtask

    // Waits until every queued result has come back.
    task automatic drain();
        while (pool.pending() != 0) @(posedge aclk);
    endtask

    // Writes both registers and the two unused indexes back to back; the block is idle.
    task automatic program_regs(input logic [CNT_W-1:0] grow_val,
                                input logic [CNT_W-1:0] limit_val);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CNT_W-1:0]     val [4];
        idx[0] = CFG_GROW_STEP;
        idx[1] = CFG_CAP_LIMIT;
        idx[2] = CFG_SPARE_A;
        idx[3] = CFG_SPARE_B;
        val[0] = grow_val;
        val[1] = limit_val;
        val[2] = CNT_W'($urandom);
        val[3] = CNT_W'($urandom);
        foreach (idx[k]) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge aclk); while (!cfg_ready);
            pool.write_reg(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random requests in bursts with random gaps, then a full drain.
    task automatic run_phase(input int items, input int alloc_pct);
        int burst;
        int gap;
        burst = 0;
        for (int i = 0; i < items; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            send(make_request(alloc_pct));
            burst--;
        end
        s_valid <= 1'b0;
        drain();
    endtask

    // Result receiver: calm windows with ready held high, random stalls elsewhere.
    initial begin : result_sink
        int cyc;
        int stall;
        cyc     = 0;
        stall   = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) pool.check_result(m_data);
            cyc++;
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if ((cyc % 640) < 160) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(5) == 0) begin
                stall = $urandom_range(1, 24);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Ends the run when no transfer happens on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Reset, directed requests, then phases through several register settings.
    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: grants from the top of the start-up stack, bad handles, double frees.
        send(request_of(REQ_ALLOC, SLOTS - 1));
        send(request_of(REQ_ALLOC, 0));
        send(request_of(REQ_FREE, SLOTS - 1));
        send(request_of(REQ_FREE, DEFAULT_STEP));
        send(request_of(REQ_FREE, DEFAULT_STEP - 1));
        send(request_of(REQ_FREE, DEFAULT_STEP - 1));
        send(request_of(REQ_FREE, 0));
        send(request_of(REQ_ALLOC, 0));
        send(request_of(REQ_FREE, DEFAULT_STEP - 2));
        send(request_of(REQ_FREE, DEFAULT_STEP - 1));
        send(request_of(REQ_ALLOC, 512));
        send(request_of(REQ_ALLOC, 341));
        s_valid <= 1'b0;
        drain();

        // Zero step acts as the default; small limit forces exhaustion.
        program_regs(11'd0, 11'd48);
        run_phase(200, 70);
        // Growth one slot at a time.
        program_regs(11'd1, 11'd64);
        run_phase(200, 65);
        // Oversized step, clipped by the limit.
        program_regs(11'd2047, 11'd100);
        run_phase(150, 65);
        // Limit below the slots already created.
        program_regs(11'd5, 11'd10);
        run_phase(150, 60);
        // Largest step with the limit at zero: one big growth to every slot.
        program_regs(11'd1024, 11'd0);
        run_phase(250, 75);
        // Full pool, oversized step and the largest limit.
        program_regs(11'd2047, 11'd1024);
        run_phase(500, 50);

        repeat (20) @(posedge aclk);
        if (pool.errors == 0 && pool.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
